// ----- hdl/pid_angle_controller_variable_dt_unit_defines.svh -----
// ---------------------------------------------------------------------------
// PID angle controller assertion macros
// Shared concurrent check macros for the controller modules.
// ---------------------------------------------------------------------------
`ifndef PID_ANGLE_CONTROLLER_VARIABLE_DT_UNIT_DEFINES_SVH
`define PID_ANGLE_CONTROLLER_VARIABLE_DT_UNIT_DEFINES_SVH

// Same-cycle implication, held off during reset
`define PIDADT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("pidadt: same-cycle check failed");

// Next-cycle implication, held off during reset
`define PIDADT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("pidadt: next-cycle check failed");

`endif

// ----- hdl/pidadt_pkg.sv -----
// ---------------------------------------------------------------------------
// PID angle controller package
// Widths, register codes, microcode words and the control program ROM.
// ---------------------------------------------------------------------------
`default_nettype none

package pidadt_pkg;

	// Port and field widths
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 23;
	localparam int ANGLE_W    = 16;
	localparam int TIME_IN_W  = 32;
	localparam int DRIVE_W    = 32;
	localparam int GAIN_W     = 8;
	localparam int LIMIT_W    = 23;

	// Datapath widths
	localparam int ERR_W   = ANGLE_W + 1;
	localparam int INTEG_W = 25;
	localparam int NUM_W   = 64;
	localparam int QUOT_W  = 42;
	localparam int DTI_W   = 31;
	localparam int KD_W    = 25;
	localparam int KI_W    = 15;
	localparam int SUM_W   = 46;
	localparam int ACC_W   = QUOT_W + 2;

	// Arithmetic constants
	localparam int INC_DIVISOR = 1000;
	localparam int KD_SCALE    = 100000;
	localparam int KI_SCALE    = 100;
	localparam int DT_CAP_LOG  = 30;

	// Increment over 1000 ms: shift out the factor 8, then multiply by the
	// reciprocal of 125, (2^32 + RECIP_LO) / 2^39, exact for 32-bit dividends.
	// Larger dividends give an increment far beyond any limit.
	localparam int INC_PRE_SHIFT = 3;
	localparam int RDIV_W        = 32;
	localparam int RECIP_SHIFT   = 39;
	localparam int RECIP_LO_W    = 27;
	localparam logic [RECIP_LO_W-1:0] RECIP_LO = 27'd103079216;
	localparam int RSUM_W        = 2 * RDIV_W + 1;
	localparam int INC_W         = RSUM_W - RECIP_SHIFT;

	// Parameter defaults
	localparam int TIME_WIDTH_DEF      = 32;
	localparam int ANGLE_FRAC_BITS_DEF = 8;

	// Register reset values
	localparam logic signed [ANGLE_W-1:0] SETPOINT_RST = '0;
	localparam logic [GAIN_W-1:0]  PROP_GAIN_RST  = 8'd9;
	localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST = 8'd2;
	localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST = 8'd3;
	localparam logic [LIMIT_W-1:0] LIMIT_RST      = 23'd65536;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SETPOINT   = 3'd0,
		CFG_PROP_GAIN  = 3'd1,
		CFG_INTEG_GAIN = 3'd2,
		CFG_DERIV_GAIN = 3'd3,
		CFG_LIMIT      = 3'd4
	} cfg_index_t;

	// Datapath operations
	typedef enum logic [3:0] {
		OP_NOP   = 4'd0,
		OP_WAIT  = 4'd1,
		OP_ERR   = 4'd2,
		OP_IMUL  = 4'd3,
		OP_DIVI  = 4'd4,
		OP_IACC  = 4'd5,
		OP_DPREP = 4'd6,
		OP_DMUL  = 4'd7,
		OP_DIVD  = 4'd8,
		OP_SUMD  = 4'd9,
		OP_SUMP  = 4'd10,
		OP_SUMI  = 4'd11,
		OP_OUT   = 4'd12
	} op_t;

	// Jump conditions
	typedef enum logic [2:0] {
		COND_NONE     = 3'd0,
		COND_ALWAYS   = 3'd1,
		COND_NO_INPUT = 3'd2,
		COND_DIV_BUSY = 3'd3,
		COND_NO_DT    = 3'd4,
		COND_OUT_FREE = 3'd5
	} cond_t;

	localparam int STEP_W = 4;
	typedef logic [STEP_W-1:0] step_t;

	localparam step_t ST_IDLE   = 4'd0;
	localparam step_t ST_ERR    = 4'd1;
	localparam step_t ST_IMUL   = 4'd2;
	localparam step_t ST_DIVI   = 4'd3;
	localparam step_t ST_IACC   = 4'd4;
	localparam step_t ST_DPREP  = 4'd5;
	localparam step_t ST_DMUL   = 4'd6;
	localparam step_t ST_DIVD   = 4'd7;
	localparam step_t ST_WAIT_D = 4'd8;
	localparam step_t ST_SUM_D  = 4'd9;
	localparam step_t ST_SUM_P  = 4'd10;
	localparam step_t ST_SUM_I  = 4'd11;
	localparam step_t ST_OUT    = 4'd12;
	localparam step_t ST_HOLD   = 4'd13;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} ctrl_t;

	typedef struct packed {
		logic in_fire;
		logic div_busy;
		logic no_dt;
		logic out_free;
	} stat_t;

	// Control program: a taken jump goes to target, otherwise to the next step
	function automatic ctrl_t ucode(input step_t step);
		ctrl_t w;
		case (step)
			ST_IDLE:   w = '{op: OP_WAIT,  cond: COND_NO_INPUT, target: ST_IDLE};
			ST_ERR:    w = '{op: OP_ERR,   cond: COND_NONE,     target: ST_IDLE};
			ST_IMUL:   w = '{op: OP_IMUL,  cond: COND_NONE,     target: ST_IDLE};
			ST_DIVI:   w = '{op: OP_DIVI,  cond: COND_NONE,     target: ST_IDLE};
			ST_IACC:   w = '{op: OP_IACC,  cond: COND_NONE,     target: ST_IDLE};
			ST_DPREP:  w = '{op: OP_DPREP, cond: COND_NO_DT,    target: ST_SUM_D};
			ST_DMUL:   w = '{op: OP_DMUL,  cond: COND_NONE,     target: ST_IDLE};
			ST_DIVD:   w = '{op: OP_DIVD,  cond: COND_NONE,     target: ST_IDLE};
			ST_WAIT_D: w = '{op: OP_NOP,   cond: COND_DIV_BUSY, target: ST_WAIT_D};
			ST_SUM_D:  w = '{op: OP_SUMD,  cond: COND_NONE,     target: ST_IDLE};
			ST_SUM_P:  w = '{op: OP_SUMP,  cond: COND_NONE,     target: ST_IDLE};
			ST_SUM_I:  w = '{op: OP_SUMI,  cond: COND_NONE,     target: ST_IDLE};
			ST_OUT:    w = '{op: OP_OUT,   cond: COND_OUT_FREE, target: ST_IDLE};
			ST_HOLD:   w = '{op: OP_NOP,   cond: COND_ALWAYS,   target: ST_OUT};
			default:   w = '{op: OP_NOP,   cond: COND_ALWAYS,   target: ST_IDLE};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/pidadt_div.sv -----
// ---------------------------------------------------------------------------
// PID angle controller divider
// Restoring divider, one quotient bit per cycle, with a saturated quotient
// when the true quotient does not fit.
// ---------------------------------------------------------------------------
`default_nettype none
`include "pid_angle_controller_variable_dt_unit_defines.svh"

module pidadt_div #(
	parameter int DIVISOR_W = pidadt_pkg::TIME_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [pidadt_pkg::NUM_W-1:0]  dividend,
	input  logic [DIVISOR_W-1:0]          divisor,
	output logic                          busy,
	output logic [pidadt_pkg::QUOT_W-1:0] quot
);
	import pidadt_pkg::*;

	localparam int HI_W  = NUM_W - QUOT_W;
	localparam int RW    = ((DIVISOR_W > HI_W) ? DIVISOR_W : HI_W) + 1;
	localparam int CNT_W = $clog2(QUOT_W);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(QUOT_W - 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [RW-1:0]    rem_q;
	logic [RW-1:0]    div_q;
	logic [QUOT_W-1:0] lo_q;
	logic             sat_q;
	logic [RW-1:0]    trial;
	logic             ge;

	// Shift in the next dividend bit and try a subtract
	assign trial = {rem_q[RW-2:0], lo_q[QUOT_W-1]};
	assign ge    = (trial >= div_q);

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == LAST) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= RW'(dividend[NUM_W-1:QUOT_W]);
			lo_q  <= dividend[QUOT_W-1:0];
			div_q <= RW'(divisor);
			sat_q <= (RW'(dividend[NUM_W-1:QUOT_W]) >= RW'(divisor));
		end else if (busy_q) begin
			rem_q <= ge ? (trial - div_q) : trial;
			lo_q  <= {lo_q[QUOT_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quot = sat_q ? '1 : lo_q;

	`PIDADT_ASSERT_IMP(a_start_idle, clk, arst_n, start, !busy_q)
	`PIDADT_ASSERT_NXT(a_last_step_ends, clk, arst_n, busy_q && (cnt_q == LAST) && !start, !busy_q)
	`PIDADT_ASSERT_IMP(a_count_range, clk, arst_n, busy_q, cnt_q <= LAST)

endmodule

`default_nettype wire

// ----- hdl/pidadt_seq.sv -----
// ---------------------------------------------------------------------------
// PID angle controller sequencer
// Step counter over the control program ROM with conditional jumps.
// ---------------------------------------------------------------------------
`default_nettype none
`include "pid_angle_controller_variable_dt_unit_defines.svh"

module pidadt_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  pidadt_pkg::stat_t stat,
	output pidadt_pkg::ctrl_t ctrl
);
	import pidadt_pkg::*;

	step_t step_q;
	logic  take;

	assign ctrl = ucode(step_q);

	// Evaluate the jump condition of the current word
	always_comb begin
		case (ctrl.cond)
			COND_NONE:     take = 1'b0;
			COND_ALWAYS:   take = 1'b1;
			COND_NO_INPUT: take = !stat.in_fire;
			COND_DIV_BUSY: take = stat.div_busy;
			COND_NO_DT:    take = stat.no_dt;
			COND_OUT_FREE: take = stat.out_free;
			default:       take = 1'b1;
		endcase
	end

	// Advance or jump
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
		end else begin
			step_q <= take ? ctrl.target : (step_q + STEP_W'(1));
		end
	end

	`PIDADT_ASSERT_NXT(a_hold_on_div, clk, arst_n, (step_q == ST_WAIT_D) && stat.div_busy, step_q == ST_WAIT_D)
	`PIDADT_ASSERT_NXT(a_skip_on_no_dt, clk, arst_n, (step_q == ST_DPREP) && stat.no_dt, step_q == ST_SUM_D)

endmodule

`default_nettype wire

// ----- hdl/pidadt_dp.sv -----
// ---------------------------------------------------------------------------
// PID angle controller datapath
// Configuration registers, controller state and the arithmetic driven by the
// control word, plus the input and output registers.
// ---------------------------------------------------------------------------
`default_nettype none
`include "pid_angle_controller_variable_dt_unit_defines.svh"

module pidadt_dp #(
	parameter int TIME_WIDTH      = pidadt_pkg::TIME_WIDTH_DEF,
	parameter int ANGLE_FRAC_BITS = pidadt_pkg::ANGLE_FRAC_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_we,
	input  logic [pidadt_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [pidadt_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic signed [pidadt_pkg::ANGLE_W-1:0]   angle,
	input  logic [pidadt_pkg::TIME_IN_W-1:0]        time_ms,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [pidadt_pkg::DRIVE_W-1:0]   drive,
	output logic                                    drive_saturated,
	output logic                                    integral_clamped,
	output logic                                    no_elapsed_time,
	input  pidadt_pkg::ctrl_t                       ctrl,
	output pidadt_pkg::stat_t                       stat,
	output logic                                    div_start,
	output logic [pidadt_pkg::NUM_W-1:0]            div_dividend,
	output logic [TIME_WIDTH-1:0]                   div_divisor,
	input  logic                                    div_busy,
	input  logic [pidadt_pkg::QUOT_W-1:0]           div_quot
);
	import pidadt_pkg::*;

	localparam int TW      = TIME_WIDTH;
	localparam int SH      = 16 - ANGLE_FRAC_BITS;
	localparam int ERRQ_W  = ERR_W + SH;
	localparam int EMAG_W  = ANGLE_W + SH;
	localparam int DIFF_W  = ERR_W + 1;
	localparam int DEQ_W   = DIFF_W + SH;
	localparam int DMAG_W  = ERR_W + SH;
	localparam int IPROD_W = EMAG_W + DTI_W;
	localparam int DPROD_W = DMAG_W + KD_W;
	localparam int PT_W    = ERRQ_W + GAIN_W + 1;
	localparam int IT_W    = INTEG_W + KI_W + 1;

	localparam logic [NUM_W-1:0]        DT_CAP  = NUM_W'(1) << DT_CAP_LOG;
	localparam logic signed [SUM_W-1:0] DRV_MAX = SUM_W'(2147483647);
	localparam logic signed [SUM_W-1:0] DRV_MIN = ~DRV_MAX;

	// Configuration registers
	logic signed [ANGLE_W-1:0] setpoint_q;
	logic [GAIN_W-1:0]         prop_q;
	logic [GAIN_W-1:0]         integ_gain_q;
	logic [GAIN_W-1:0]         deriv_q;
	logic [LIMIT_W-1:0]        limit_q;

	// Controller state
	logic signed [INTEG_W-1:0] integ_q;
	logic signed [ERR_W-1:0]   prev_q;
	logic [TW-1:0]             last_ts_q;

	// Working registers
	logic signed [ANGLE_W-1:0] angle_q;
	logic [TW-1:0]             now_q;
	logic signed [ERR_W-1:0]   err_q;
	logic [TW-1:0]             dt_q;
	logic                      nodt_q;
	logic                      ineg_q;
	logic                      dneg_q;
	logic [DMAG_W-1:0]         dmag_q;
	logic [KD_W-1:0]           kd_q;
	logic [KI_W-1:0]           ki_q;
	logic [NUM_W-1:0]          prod_q;
	logic [INC_W-1:0]          inc_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic                      clamp_q;

	// Output register
	logic                      out_valid_q;
	logic signed [DRIVE_W-1:0] drive_q;
	logic                      sat_q;
	logic                      oclamp_q;
	logic                      onodt_q;

	// Combinational terms
	logic                      in_fire;
	logic                      out_free;
	logic signed [ERRQ_W-1:0]  errq_w;
	logic [EMAG_W-1:0]         emag_w;
	logic [DTI_W-1:0]          dti_w;
	logic [IPROD_W-1:0]        iprod_w;
	logic                      rbig_w;
	logic [RDIV_W-1:0]         rdiv_w;
	logic [RDIV_W+RECIP_LO_W-1:0] rlo_w;
	logic [RSUM_W-1:0]         rsum_w;
	logic signed [INC_W:0]     inc_w;
	logic signed [QUOT_W:0]    qs_w;
	logic signed [ACC_W-1:0]   acc_w;
	logic signed [ACC_W-1:0]   lim_w;
	logic signed [DIFF_W-1:0]  diff_w;
	logic signed [DEQ_W-1:0]   deq_w;
	logic [DPROD_W-1:0]        dprod_w;
	logic signed [PT_W-1:0]    pterm_w;
	logic signed [IT_W-1:0]    iterm_w;

	assign in_ready = (ctrl.op == OP_WAIT);
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign stat.in_fire  = in_fire;
	assign stat.div_busy = div_busy;
	assign stat.no_dt    = nodt_q;
	assign stat.out_free = out_free;

	// Error scaling, integral increment operands
	assign errq_w  = ERRQ_W'(err_q) <<< SH;
	assign emag_w  = EMAG_W'(errq_w[ERRQ_W-1] ? -errq_w : errq_w);
	assign dti_w   = (NUM_W'(dt_q) > DT_CAP) ? DTI_W'(DT_CAP) : DTI_W'(dt_q);
	assign iprod_w = emag_w * dti_w;

	// Increment magnitude over 1000 by reciprocal multiplication
	assign rbig_w = |prod_q[NUM_W-1:RDIV_W+INC_PRE_SHIFT];
	assign rdiv_w = prod_q[RDIV_W+INC_PRE_SHIFT-1:INC_PRE_SHIFT];
	assign rlo_w  = rdiv_w * RECIP_LO;
	assign rsum_w = {1'b0, rdiv_w, RDIV_W'(0)} + RSUM_W'(rlo_w);

	// Signed increment and clamped integral sum
	assign inc_w = $signed({1'b0, inc_q});
	assign acc_w = ACC_W'(integ_q) + ACC_W'(ineg_q ? -inc_w : inc_w);
	assign lim_w = ACC_W'($signed({1'b0, limit_q}));

	// Signed derivative quotient
	assign qs_w = $signed({1'b0, div_quot});

	// Error change scaling
	assign diff_w  = DIFF_W'(err_q) - DIFF_W'(prev_q);
	assign deq_w   = DEQ_W'(diff_w) <<< SH;
	assign dprod_w = dmag_q * kd_q;

	// Proportional and integral terms
	assign pterm_w = $signed({1'b0, prop_q}) * errq_w;
	assign iterm_w = $signed({1'b0, ki_q}) * integ_q;

	// Divider launch
	assign div_start    = (ctrl.op == OP_DIVD);
	assign div_dividend = prod_q;
	assign div_divisor  = dt_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q   <= SETPOINT_RST;
			prop_q       <= PROP_GAIN_RST;
			integ_gain_q <= INTEG_GAIN_RST;
			deriv_q      <= DERIV_GAIN_RST;
			limit_q      <= LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_SETPOINT:   setpoint_q   <= cfg_data[ANGLE_W-1:0];
				CFG_PROP_GAIN:  prop_q       <= cfg_data[GAIN_W-1:0];
				CFG_INTEG_GAIN: integ_gain_q <= cfg_data[GAIN_W-1:0];
				CFG_DERIV_GAIN: deriv_q      <= cfg_data[GAIN_W-1:0];
				CFG_LIMIT:      limit_q      <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// Controller state and result handoff
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q     <= '0;
			prev_q      <= '0;
			last_ts_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.op == OP_IACC) begin
				if (acc_w > lim_w) begin
					integ_q <= INTEG_W'(lim_w);
				end else if (acc_w < -lim_w) begin
					integ_q <= INTEG_W'(-lim_w);
				end else begin
					integ_q <= INTEG_W'(acc_w);
				end
			end
			if ((ctrl.op == OP_OUT) && out_free) begin
				prev_q      <= err_q;
				last_ts_q   <= now_q;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers, one operation per control word
	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_WAIT: begin
				if (in_fire) begin
					angle_q <= angle;
					now_q   <= TW'(time_ms);
				end
			end
			OP_ERR: begin
				err_q  <= ERR_W'(setpoint_q) - ERR_W'(angle_q);
				dt_q   <= now_q - last_ts_q;
				nodt_q <= (now_q == last_ts_q);
				kd_q   <= KD_W'(deriv_q * KD_W'(KD_SCALE));
			end
			OP_IMUL: begin
				prod_q <= NUM_W'(iprod_w);
				ineg_q <= err_q[ERR_W-1];
			end
			OP_DIVI: begin
				inc_q <= rbig_w ? '1 : rsum_w[RSUM_W-1:RECIP_SHIFT];
			end
			OP_IACC: begin
				clamp_q <= (acc_w > lim_w) || (acc_w < -lim_w);
			end
			OP_DPREP: begin
				dmag_q <= DMAG_W'(deq_w[DEQ_W-1] ? -deq_w : deq_w);
				dneg_q <= deq_w[DEQ_W-1];
				ki_q   <= KI_W'(integ_gain_q * KI_W'(KI_SCALE));
			end
			OP_DMUL: begin
				prod_q <= NUM_W'(dprod_w);
			end
			OP_SUMD: begin
				sum_q <= nodt_q ? '0 : SUM_W'(dneg_q ? -qs_w : qs_w);
			end
			OP_SUMP: begin
				sum_q <= sum_q + SUM_W'(pterm_w);
			end
			OP_SUMI: begin
				sum_q <= sum_q + SUM_W'(iterm_w);
			end
			OP_OUT: begin
				if (out_free) begin
					if (sum_q > DRV_MAX) begin
						drive_q <= DRIVE_W'(DRV_MAX);
						sat_q   <= 1'b1;
					end else if (sum_q < DRV_MIN) begin
						drive_q <= DRIVE_W'(DRV_MIN);
						sat_q   <= 1'b1;
					end else begin
						drive_q <= DRIVE_W'(sum_q);
						sat_q   <= 1'b0;
					end
					oclamp_q <= clamp_q;
					onodt_q  <= nodt_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid        = out_valid_q;
	assign drive            = drive_q;
	assign drive_saturated  = sat_q;
	assign integral_clamped = oclamp_q;
	assign no_elapsed_time  = onodt_q;

	`PIDADT_ASSERT_NXT(a_no_dt_zero_d, clk, arst_n, (ctrl.op == OP_SUMD) && nodt_q, sum_q == '0)
	`PIDADT_ASSERT_IMP(a_div_idle_at_start, clk, arst_n, div_start, !div_busy)

endmodule

`default_nettype wire

// ----- hdl/pid_angle_controller_variable_dt_unit.sv -----
// ---------------------------------------------------------------------------
// PID angle controller, variable time step
// Tilt controller with integral clamp and saturated Q16.16 output.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one angle sample in signed
//   fixed point and a millisecond timestamp. in_ready is high only while the
//   sequencer sits on its idle step, so one sample is processed at a time.
//   Output channel (out_valid/out_ready) carries drive with its saturation,
//   integral clamp and zero elapsed time flags, one result per sample.
//   Most of the time from input transfer to output valid goes to the 42-step
//   pass of the restoring divider for the error change over elapsed time,
//   which is skipped when no time has elapsed; the increment over 1000 ms is
//   a one-step reciprocal multiply. The finished result sits in an output
//   register, so the next sample is transferred while it waits; a stalled
//   receiver holds the sequencer on its output step until the register
//   frees up. Registers are written over cfg_we/cfg_index/cfg_data while
//   idle; the user must keep to this, the block itself does not enforce it.
//   Reset clears the integral, previous error and last timestamp to zero,
//   loads the register defaults and drops out_valid.
// ---------------------------------------------------------------------------
`default_nettype none

module pid_angle_controller_variable_dt_unit #(
	parameter int TIME_WIDTH      = pidadt_pkg::TIME_WIDTH_DEF,
	parameter int ANGLE_FRAC_BITS = pidadt_pkg::ANGLE_FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [pidadt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pidadt_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [pidadt_pkg::ANGLE_W-1:0] angle,
	input  logic [pidadt_pkg::TIME_IN_W-1:0]      time_ms,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [pidadt_pkg::DRIVE_W-1:0] drive,
	output logic                                  drive_saturated,
	output logic                                  integral_clamped,
	output logic                                  no_elapsed_time
);
	import pidadt_pkg::*;

	ctrl_t                ctrl;
	stat_t                stat;
	logic                 div_start;
	logic [NUM_W-1:0]     div_dividend;
	logic [TIME_WIDTH-1:0] div_divisor;
	logic                 div_busy;
	logic [QUOT_W-1:0]    div_quot;

	// Divider for the derivative quotient
	pidadt_div #(
		.DIVISOR_W (TIME_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.quot     (div_quot)
	);

	// Control program sequencer
	pidadt_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	// Datapath
	pidadt_dp #(
		.TIME_WIDTH      (TIME_WIDTH),
		.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.angle            (angle),
		.time_ms          (time_ms),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.drive            (drive),
		.drive_saturated  (drive_saturated),
		.integral_clamped (integral_clamped),
		.no_elapsed_time  (no_elapsed_time),
		.ctrl             (ctrl),
		.stat             (stat),
		.div_start        (div_start),
		.div_dividend     (div_dividend),
		.div_divisor      (div_divisor),
		.div_busy         (div_busy),
		.div_quot         (div_quot)
	);

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// ---------------------------------------------------------------------------
// PID angle controller testbench
// Drives angle samples with timestamps through the valid/ready input, keeps
// a cycle-free copy of the controller's integer arithmetic to predict each
// drive result, and checks every output transfer field by field. Register
// settings change between phases while the block is idle.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;

	import pidadt_pkg::*;

	localparam int          RESET_CYCLES      = 11;
	localparam int          RANDOM_PHASES     = 8;
	localparam int          SAMPLES_PER_PHASE = 173;
	localparam int          LONG_HOLD_CYCLES  = 3000;
	localparam int          END_SLACK         = 200;
	localparam int unsigned CYCLE_LIMIT       = 1000000;
	localparam int          MISMATCH_PRINTS   = 200;

	localparam longint          ERR_SCALE = longint'(1) << (16 - ANGLE_FRAC_BITS_DEF);
	localparam longint unsigned DT_CAP    = longint'(1) << DT_CAP_LOG;
	localparam longint          DRIVE_MAX = 2147483647;
	localparam longint          DRIVE_MIN = -DRIVE_MAX - 1;

	// Register indexes past the end of the register list
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = 3'd7;

	typedef struct {
		logic signed [ANGLE_W-1:0] angle;
		logic [TIME_IN_W-1:0]      stamp;
	} sample_t;

	typedef struct {
		logic signed [DRIVE_W-1:0] drive;
		logic                      saturated;
		logic                      clamped;
		logic                      no_dt;
	} result_t;

	// DUT signals
	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]      cfg_index = '0;
	logic [CFG_DATA_W-1:0]     cfg_data = '0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic signed [ANGLE_W-1:0] angle = '0;
	logic [TIME_IN_W-1:0]      time_ms = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic signed [DRIVE_W-1:0] drive;
	logic                      drive_saturated;
	logic                      integral_clamped;
	logic                      no_elapsed_time;

	// Register copies
	logic signed [ANGLE_W-1:0] setpoint_r    = SETPOINT_RST;
	logic [GAIN_W-1:0]         prop_gain_r   = PROP_GAIN_RST;
	logic [GAIN_W-1:0]         integ_gain_r  = INTEG_GAIN_RST;
	logic [GAIN_W-1:0]         deriv_gain_r  = DERIV_GAIN_RST;
	logic [LIMIT_W-1:0]        integ_limit_r = LIMIT_RST;

	// Controller state copies
	longint               integ_accum = 0;
	longint               prev_err = 0;
	logic [TIME_IN_W-1:0] last_stamp = '0;

	sample_t sample_fifo[$];
	result_t drive_expected[$];
	int      queued_total = 0;
	int      accepted_total = 0;
	int      mismatches = 0;
	int      send_idle_pct = 0;
	int      recv_stall_pct = 0;
	int      hold_req = 0;
	int      hold_ack = 0;
	int      hold_left = 0;
	int unsigned cycle_count = 0;
	logic [TIME_IN_W-1:0] stamp_now = '0;

	pid_angle_controller_variable_dt_unit u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.angle            (angle),
		.time_ms          (time_ms),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.drive            (drive),
		.drive_saturated  (drive_saturated),
		.integral_clamped (integral_clamped),
		.no_elapsed_time  (no_elapsed_time)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Signed value times a scale over a divisor, truncated toward zero
	function automatic longint scaled_quotient(input longint num, input longint unsigned mul,
			input longint unsigned dvs);
		longint unsigned mag;
		longint unsigned q;
		mag = (num < 0) ? -num : num;
		q = (mag * mul) / dvs;
		return (num < 0) ? -longint'(q) : longint'(q);
	endfunction

	// Advance the controller state by one sample and return its drive result
	function automatic result_t predict_drive(input logic signed [ANGLE_W-1:0] a,
			input logic [TIME_IN_W-1:0] t);
		result_t              r;
		logic [TIME_IN_W-1:0] elapsed;
		longint               err;
		longint               errq;
		longint               acc;
		longint               lim;
		longint               p_part;
		longint               i_part;
		longint               d_part;
		longint               sum;
		longint unsigned      dt_int;
		elapsed = t - last_stamp;
		err = longint'(setpoint_r) - longint'(a);
		errq = err * ERR_SCALE;
		lim = integ_limit_r;

		// integrate over the capped window, then clamp to the limit
		dt_int = (elapsed > DT_CAP) ? DT_CAP : elapsed;
		acc = integ_accum + scaled_quotient(errq, dt_int, INC_DIVISOR);
		r.clamped = 1'b0;
		if (acc > lim) begin
			acc = lim;
			r.clamped = 1'b1;
		end else if (acc < -lim) begin
			acc = -lim;
			r.clamped = 1'b1;
		end
		integ_accum = acc;

		p_part = longint'(prop_gain_r) * errq;
		i_part = longint'(KI_SCALE) * longint'(integ_gain_r) * integ_accum;
		r.no_dt = (elapsed == '0);
		if (r.no_dt) begin
			d_part = 0;
		end else begin
			d_part = scaled_quotient((err - prev_err) * ERR_SCALE,
				longint'(KD_SCALE) * longint'(deriv_gain_r), elapsed);
		end

		// saturate the exact sum to 32 bits
		sum = p_part + i_part + d_part;
		r.saturated = 1'b1;
		if (sum > DRIVE_MAX) begin
			sum = DRIVE_MAX;
		end else if (sum < DRIVE_MIN) begin
			sum = DRIVE_MIN;
		end else begin
			r.saturated = 1'b0;
		end
		r.drive = sum[DRIVE_W-1:0];

		prev_err = err;
		last_stamp = t;
		return r;
	endfunction

	task automatic flag_mismatch(input string field, input longint want, input longint got);
		mismatches++;
		if (mismatches <= MISMATCH_PRINTS) begin
			$error("%s mismatch: expected %0d, got %0d", field, want, got);
		end
	endtask

	// Start or continue a burst of register writes on the next edge
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_SETPOINT:   setpoint_r = val[ANGLE_W-1:0];
			CFG_PROP_GAIN:  prop_gain_r = val[GAIN_W-1:0];
			CFG_INTEG_GAIN: integ_gain_r = val[GAIN_W-1:0];
			CFG_DERIV_GAIN: deriv_gain_r = val[GAIN_W-1:0];
			CFG_LIMIT:      integ_limit_r = val[LIMIT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic end_writes();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Full-width values exercise the masking of narrow registers
	task automatic randomize_registers();
		write_reg(CFG_SETPOINT, CFG_DATA_W'($urandom));
		write_reg(CFG_PROP_GAIN, CFG_DATA_W'($urandom));
		write_reg(CFG_INTEG_GAIN, CFG_DATA_W'($urandom));
		write_reg(CFG_DERIV_GAIN, CFG_DATA_W'($urandom));
		write_reg(CFG_LIMIT, ($urandom_range(1) != 0) ? CFG_DATA_W'($urandom) :
			CFG_DATA_W'($urandom_range(262143)));
	endtask

	task automatic queue_sample(input logic signed [ANGLE_W-1:0] a, input logic [TIME_IN_W-1:0] t);
		sample_fifo.push_back('{angle: a, stamp: t});
		queued_total++;
	endtask

	// Mostly steady control-loop time steps near the setpoint, some noise
	task automatic queue_random_sample();
		logic signed [ANGLE_W-1:0] a;
		case ($urandom_range(9))
			0: ;
			1: stamp_now = stamp_now + $urandom;
			2: stamp_now = $urandom;
			default: stamp_now = stamp_now + $urandom_range(1, 40);
		endcase
		if ($urandom_range(3) == 0) begin
			a = ANGLE_W'($urandom);
		end else begin
			a = setpoint_r + ANGLE_W'($urandom_range(2047)) - ANGLE_W'(1024);
		end
		queue_sample(a, stamp_now);
	endtask

	// Hold until every queued sample is transferred and every result is back
	task automatic wait_drained();
		while (accepted_total != queued_total || drive_expected.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Sender: offer queued samples, predict on each transfer
	always @(posedge clk) begin
		sample_t s;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				drive_expected.push_back(predict_drive(angle, time_ms));
				accepted_total++;
			end
			if (!in_valid || in_ready) begin
				if (sample_fifo.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					s = sample_fifo.pop_front();
					in_valid <= 1'b1;
					angle <= s.angle;
					time_ms <= s.stamp;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: check each result transfer, then pick the next ready
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (drive_expected.size() == 0) begin
					mismatches++;
					$error("result with no sample pending: drive %0d", drive);
				end else begin
					want = drive_expected.pop_front();
					if (drive !== want.drive)
						flag_mismatch("drive", want.drive, drive);
					if (drive_saturated !== want.saturated)
						flag_mismatch("drive_saturated", want.saturated, drive_saturated);
					if (integral_clamped !== want.clamped)
						flag_mismatch("integral_clamped", want.clamped, integral_clamped);
					if (no_elapsed_time !== want.no_dt)
						flag_mismatch("no_elapsed_time", want.no_dt, no_elapsed_time);
				end
			end
			if (hold_left != 0) begin
				out_ready <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (hold_req != hold_ack) begin
				out_ready <= 1'b0;
				hold_ack <= hold_req;
				hold_left <= LONG_HOLD_CYCLES;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Timeout
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		int ph;
		int k;
		int mode;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: reset registers, first step from stamp zero, extremes,
		// zero elapsed time, very long gaps and timestamp wrap
		queue_sample(16'sh0000, 32'd0);
		queue_sample(16'sh7FFF, 32'd1);
		queue_sample(16'sh8000, 32'd2);
		queue_sample(16'sh8000, 32'd2);
		queue_sample(16'sh0000, 32'd1002);
		queue_sample(16'sh0100, 32'd1003);
		queue_sample(16'shFF00, 32'h8000_03EB);
		queue_sample(16'sh7FFF, 32'hFFFF_FFF0);
		queue_sample(16'sh8000, 32'h0000_0005);
		queue_sample(16'sh0001, 32'h0000_0006);
		queue_sample(16'shFFFF, 32'hFFFF_FFFF);
		queue_sample(16'sh0000, 32'hFFFF_FFFF);
		queue_sample(16'sh5555, 32'hAAAA_AAAA);
		queue_sample(16'shAAAA, 32'h5555_5555);
		queue_sample(16'sh0064, 32'h5555_5556);
		wait_drained();
		stamp_now = last_stamp;

		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: begin
					write_reg(CFG_SETPOINT, 23'h007FFF);
					write_reg(CFG_PROP_GAIN, 23'd255);
					write_reg(CFG_INTEG_GAIN, 23'd255);
					write_reg(CFG_DERIV_GAIN, 23'd255);
					write_reg(CFG_LIMIT, 23'h7FFFFF);
				end
				1: begin
					// setpoint sign bit with upper junk bits, zero limit
					write_reg(CFG_SETPOINT, 23'h7F8000);
					write_reg(CFG_PROP_GAIN, 23'd0);
					write_reg(CFG_INTEG_GAIN, 23'h7FFF01);
					write_reg(CFG_DERIV_GAIN, 23'd0);
					write_reg(CFG_LIMIT, 23'd0);
				end
				2: begin
					randomize_registers();
					write_reg(CFG_SPARE_FIRST, CFG_DATA_W'($urandom));
					write_reg(CFG_SPARE_LAST, CFG_DATA_W'($urandom));
				end
				default: randomize_registers();
			endcase
			end_writes();

			// Idle mix: none, sender mostly idle, receiver mostly stalled, both light
			mode = ph % 4;
			send_idle_pct <= (mode == 1) ? 85 : (mode == 3) ? 9 : 0;
			recv_stall_pct <= (mode == 2) ? 85 : (mode == 3) ? 9 : 0;
			if (ph == 4)
				hold_req <= hold_req + 1;

			for (k = 0; k < SAMPLES_PER_PHASE; k++)
				queue_random_sample();
			wait_drained();
		end

		repeat (END_SLACK) @(posedge clk);
		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

`default_nettype wire
